// ===== rtl/cpls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpls_pkg
// Shared widths and operation codes for the critical path list scheduler.
// ----------------------------------------------------------------------------
package cpls_pkg;
   localparam int NODES  = 32;
   localparam int IDX_W  = 5;
   localparam int CNT_W  = 6;
   localparam int LAT_W  = 8;
   localparam int PRIO_W = 13;
   localparam int CYC_W  = 15;
   localparam logic [PRIO_W-1:0] PRIO_MAX = 13'd8191;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LAT   = 2'd1;
   localparam logic [1:0] OP_EDGE  = 2'd2;
   localparam logic [1:0] OP_RUN   = 2'd3;

   localparam logic [1:0] KIND_RAW = 2'd0;
   localparam logic [1:0] KIND_BAD = 2'd3;

   typedef struct packed {
      logic              lat_we;
      logic              edge_we;
      logic              clear;
      logic [IDX_W-1:0]  node;
      logic [LAT_W-1:0]  lat;
      logic [IDX_W-1:0]  src;
      logic [IDX_W-1:0]  dst;
      logic [1:0]        kind;
   } graph_wr_type;
endpackage

// ===== rtl/cpls_graph.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpls_graph
// Latency table and RAW / ordering adjacency matrices with bit and column reads.
// ----------------------------------------------------------------------------
module cpls_graph
   import cpls_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  graph_wr_type       wr,
   input  logic [IDX_W-1:0]   row_idx,
   input  logic [IDX_W-1:0]   col_idx,
   input  logic [IDX_W-1:0]   lat_idx,
   output logic               raw_bit,
   output logic               ord_bit,
   output logic [NODES-1:0]   raw_col,
   output logic [NODES-1:0]   ord_col,
   output logic [LAT_W-1:0]   lat_out
);
   logic [NODES-1:0] raw_ff [NODES];
   logic [NODES-1:0] ord_ff [NODES];
   logic [LAT_W-1:0] lat_ff [NODES];

   always_ff @(posedge clock) begin
      if (reset || wr.clear) begin
         for (int r = 0; r < NODES; r++) begin
            raw_ff[r] <= '0;
            ord_ff[r] <= '0;
         end
      end else if (wr.edge_we && wr.dst > wr.src && wr.kind != KIND_BAD) begin
         if (wr.kind == KIND_RAW) raw_ff[wr.src][wr.dst] <= 1'b1;
         else                     ord_ff[wr.src][wr.dst] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.clear) begin
         for (int r = 0; r < NODES; r++) lat_ff[r] <= '0;
      end else if (wr.lat_we) begin
         lat_ff[wr.node] <= wr.lat;
      end
   end

   always_comb begin
      for (int r = 0; r < NODES; r++) begin
         raw_col[r] = raw_ff[r][col_idx];
         ord_col[r] = ord_ff[r][col_idx];
      end
   end

   assign raw_bit = raw_ff[row_idx][col_idx];
   assign ord_bit = ord_ff[row_idx][col_idx];
   assign lat_out = (lat_ff[lat_idx] == '0) ? LAT_W'(1) : lat_ff[lat_idx];
endmodule

// ===== rtl/critical_path_list_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// critical_path_list_scheduler
// List scheduler: critical path priorities, then at most one issue per schedule cycle.
// ----------------------------------------------------------------------------
// Load words (clear, latency, edge) are taken back to back while idle. A run
// computes priorities row by row from the last node down, one compare per
// edge slot, then a setup step; each schedule
// cycle then compares readiness and priority node by node and decides, plus
// an issue step when a node goes out; a held result word stalls the issue.
// The block is not ready until the last issue.
// Synchronous active-high reset: no edges (latencies kept), node_count 1, no result pending.
// ----------------------------------------------------------------------------
module critical_path_list_scheduler
   import cpls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[1:0], node_index[6:2], latency[14:7], edge_source[19:15],
   // edge_target[24:20], edge_kind[26:25], zero pad
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // issued_node[4:0], issue_cycle[18:5], node_priority[31:19],
   // cycle_total[46:32], zero pad
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);
   typedef enum logic [2:0] {
      S_IDLE, S_PRIO, S_INIT, S_SCAN, S_ISSUE
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   node_count_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [IDX_W-1:0]   i_ff;
   logic [CNT_W-1:0]   j_ff;
   logic [PRIO_W-1:0]  best_raw_ff, best_ord_ff;
   logic               any_ff;
   logic [PRIO_W-1:0]  prio_ff [NODES];
   logic [CYC_W-1:0]   comp_ff [NODES];
   logic [NODES-1:0]   issued_ff, rawdone_ff;
   logic [CYC_W-1:0]   cycle_ff;
   logic [CNT_W-1:0]   left_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [PRIO_W-1:0]  best_prio_ff;

   logic               out_v_ff, out_last_ff;
   logic [IDX_W-1:0]   out_node_ff;
   logic [13:0]        out_cyc_ff;
   logic [PRIO_W-1:0]  out_prio_ff;
   logic [CYC_W-1:0]   out_total_ff;

   // input word fields
   logic [1:0]         in_op;
   logic               accept;
   graph_wr_type       gwr;
   logic               raw_bit, ord_bit;
   logic [NODES-1:0]   raw_col, ord_col;
   logic [LAT_W-1:0]   lat_rd;
   logic [IDX_W-1:0]   jj;

   assign in_op      = req_tdata[1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign jj         = j_ff[IDX_W-1:0];

   always_comb begin
      gwr.clear   = accept && in_op == OP_CLEAR;
      gwr.lat_we  = accept && in_op == OP_LAT;
      gwr.edge_we = accept && in_op == OP_EDGE;
      gwr.node    = req_tdata[6:2];
      gwr.lat     = req_tdata[14:7];
      gwr.src     = req_tdata[19:15];
      gwr.dst     = req_tdata[24:20];
      gwr.kind    = req_tdata[26:25];
   end

   cpls_graph u_graph (
      .clock   (clock),
      .reset   (reset),
      .wr      (gwr),
      .row_idx (i_ff),
      .col_idx (jj),
      .lat_idx ((state_ff == S_ISSUE) ? best_idx_ff : i_ff),
      .raw_bit (raw_bit),
      .ord_bit (ord_bit),
      .raw_col (raw_col),
      .ord_col (ord_col),
      .lat_out (lat_rd)
   );

   // priority of row i once its successor scan is through
   logic [PRIO_W:0]    lat_sum;
   logic [PRIO_W-1:0]  lat_sat, row_prio;
   always_comb begin
      lat_sum = {1'b0, best_raw_ff} + (PRIO_W+1)'(lat_rd);
      lat_sat = lat_sum[PRIO_W] ? PRIO_MAX : lat_sum[PRIO_W-1:0];
      if (!any_ff)               row_prio = PRIO_W'(lat_rd);
      else if (best_raw_ff != 0) row_prio = (best_ord_ff > lat_sat) ? best_ord_ff : lat_sat;
      else                       row_prio = best_ord_ff;
   end

   // readiness of node jj: every order predecessor issued, every RAW one done
   logic ready_j, done_j;
   assign done_j  = issued_ff[jj] && comp_ff[jj] == cycle_ff;
   assign ready_j = !issued_ff[jj] &&
                    ((ord_col & ~issued_ff) | (raw_col & ~rawdone_ff)) == '0;

   logic out_free;
   assign out_free = !out_v_ff || rsp_tready;

   // result word held until taken, loaded by the issue step
   logic out_v_in;
   assign out_v_in = ((state_ff == S_ISSUE) && out_free) || (out_v_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= CNT_W'(1);
         out_v_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) node_count_ff <= csr_wr_data;
         out_v_ff <= out_v_in;
         unique case (state_ff)
            S_IDLE: begin
               if (accept && in_op == OP_RUN) begin
                  if (node_count_ff != 0) begin
                     n_ff        <= (node_count_ff > CNT_W'(NODES)) ? CNT_W'(NODES)
                                                                   : node_count_ff;
                     i_ff        <= (node_count_ff > CNT_W'(NODES)) ? IDX_W'(NODES-1)
                                                                   : IDX_W'(node_count_ff - 1'b1);
                     j_ff        <= (node_count_ff > CNT_W'(NODES)) ? CNT_W'(NODES)
                                                                   : node_count_ff;
                     best_raw_ff <= '0;
                     best_ord_ff <= '0;
                     any_ff      <= 1'b0;
                     state_ff    <= S_PRIO;
                  end
               end
            end
            S_PRIO: begin
               if (j_ff < n_ff) begin
                  if (raw_bit || ord_bit) any_ff <= 1'b1;
                  if (raw_bit) begin
                     if (prio_ff[jj] > best_raw_ff) best_raw_ff <= prio_ff[jj];
                  end
                  if (ord_bit) begin
                     if (prio_ff[jj] > best_ord_ff) best_ord_ff <= prio_ff[jj];
                  end
                  j_ff <= j_ff + 1'b1;
               end else begin
                  prio_ff[i_ff] <= row_prio;
                  best_raw_ff   <= '0;
                  best_ord_ff   <= '0;
                  any_ff        <= 1'b0;
                  if (i_ff == 0) begin
                     state_ff <= S_INIT;
                  end else begin
                     j_ff <= CNT_W'(i_ff);
                     i_ff <= i_ff - 1'b1;
                  end
               end
            end
            S_INIT: begin
               issued_ff  <= '0;
               rawdone_ff <= '0;
               cycle_ff   <= '0;
               left_ff    <= n_ff;
               j_ff       <= '0;
               found_ff   <= 1'b0;
               state_ff   <= S_SCAN;
            end
            S_SCAN: begin
               if (j_ff < n_ff) begin
                  if (done_j) rawdone_ff[jj] <= 1'b1;
                  if (ready_j && (!found_ff || prio_ff[jj] > best_prio_ff)) begin
                     found_ff     <= 1'b1;
                     best_idx_ff  <= jj;
                     best_prio_ff <= prio_ff[jj];
                  end
                  j_ff <= j_ff + 1'b1;
               end else if (found_ff) begin
                  state_ff <= S_ISSUE;
               end else begin
                  // idle schedule cycle
                  cycle_ff <= cycle_ff + 1'b1;
                  j_ff     <= '0;
               end
            end
            S_ISSUE: begin
               if (out_free) begin
                  out_node_ff           <= best_idx_ff;
                  out_cyc_ff            <= cycle_ff[13:0];
                  out_prio_ff           <= best_prio_ff;
                  out_last_ff           <= (left_ff == CNT_W'(1));
                  out_total_ff          <= (left_ff == CNT_W'(1)) ? cycle_ff + 1'b1 : '0;
                  issued_ff[best_idx_ff] <= 1'b1;
                  comp_ff[best_idx_ff]  <= cycle_ff + CYC_W'(lat_rd);
                  left_ff               <= left_ff - 1'b1;
                  cycle_ff              <= cycle_ff + 1'b1;
                  j_ff                  <= '0;
                  found_ff              <= 1'b0;
                  state_ff              <= (left_ff == CNT_W'(1)) ? S_IDLE : S_SCAN;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_total_ff, out_prio_ff, out_cyc_ff, out_node_ff};
endmodule

// ===== test/tb_critical_path_list_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_critical_path_list_scheduler
// Self-checking bench for the critical path list scheduler.
// ----------------------------------------------------------------------------
// Graph words (clear, latency, edge, run) go in from a queue through a bursty
// driver. Each accepted run word is scheduled by a local model of the block.
// The model queues the expected issue words. A monitor with its own stall
// pattern checks every result word against the oldest expectation.
// The node count changes only while the block is idle, between phases.
// ----------------------------------------------------------------------------
module tb_critical_path_list_scheduler;
   import cpls_pkg::*;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int SETTLE       = 200;    // idle cycles before a csr write
   localparam int LONG_HOLD    = 3000;

   // one issue word as the block reports it
   typedef struct {
      logic [4:0]  node;
      logic [13:0] cyc;
      logic [12:0] prio;
      logic        last;
      logic [14:0] total;
   } issue_rec_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [5:0]  csr_wr_data = '0;

   critical_path_list_scheduler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // words waiting for the driver, issue words waiting for the monitor
   logic [31:0]   graph_words[$];
   issue_rec_type issue_q[$];

   int errors      = 0;
   int results_ok  = 0;
   int runs_seen   = 0;
   int words_sent  = 0;
   int cycles      = 0;
   int phases      = 0;

   // ---------------------------------------------------------------------
   // Scheduler model state
   // ---------------------------------------------------------------------
   logic [LAT_W-1:0] lat_tab[NODES];
   bit               raw_m[NODES][NODES];
   bit               ord_m[NODES][NODES];
   int               prio_tab[NODES];
   int               pend[NODES];
   int               done_at[NODES];
   bit               issued[NODES];
   int               node_cfg = 1;

   function automatic int eff_lat(int i);
      return (lat_tab[i] == 0) ? 1 : int'(lat_tab[i]);
   endfunction

   task automatic clear_graph_model();
      for (int i = 0; i < NODES; i++) begin
         lat_tab[i] = '0;
         prio_tab[i] = 0;
         pend[i] = 0;
         done_at[i] = 0;
         issued[i] = 0;
         for (int j = 0; j < NODES; j++) begin
            raw_m[i][j] = 0;
            ord_m[i][j] = 0;
         end
      end
   endtask

   // run: priorities from the last node down, then list scheduling
   task automatic schedule_run();
      int n;
      int left;
      int cyc;
      int best;
      int k;
      int best_raw;
      int best_ord;
      int p;
      bit any;
      issue_rec_type r;
      n = (node_cfg > NODES) ? NODES : node_cfg;
      k = 0;
      for (int i = n - 1; i >= 0; i--) begin
         best_raw = 0;
         best_ord = 0;
         any = 0;
         for (int j = i + 1; j < n; j++) begin
            if (raw_m[i][j]) begin
               any = 1;
               if (prio_tab[j] > best_raw) best_raw = prio_tab[j];
            end
            if (ord_m[i][j]) begin
               any = 1;
               if (prio_tab[j] > best_ord) best_ord = prio_tab[j];
            end
         end
         if (!any) p = eff_lat(i);
         else if (best_raw != 0) begin
            p = eff_lat(i) + best_raw;
            if (best_ord > p) p = best_ord;
         end else p = best_ord;
         prio_tab[i] = (p > int'(PRIO_MAX)) ? int'(PRIO_MAX) : p;
      end
      for (int j = 0; j < n; j++) begin
         pend[j] = 0;
         for (int i = 0; i < j; i++) pend[j] += int'(raw_m[i][j]) + int'(ord_m[i][j]);
         issued[j] = 0;
      end
      cyc = 0;
      left = n;
      while (left > 0) begin
         best = -1;
         for (int i = 0; i < n; i++) begin
            if (issued[i] || pend[i] != 0) continue;
            if (best < 0 || prio_tab[i] > prio_tab[best]) best = i;
         end
         if (best >= 0) begin
            issued[best] = 1;
            done_at[best] = cyc + eff_lat(best);
            r.node  = best[4:0];
            r.cyc   = cyc[13:0];
            r.prio  = 13'(prio_tab[best]);
            r.last  = 1'b0;
            r.total = '0;
            issue_q.insert(issue_q.size(), r);
            k++;
            left--;
            // ordering successors are free at issue
            for (int j = 0; j < n; j++)
               if (ord_m[best][j] && pend[j] > 0) pend[j]--;
         end
         cyc++;
         // true dependences free when the producer's latency expires
         for (int i = 0; i < n; i++) begin
            if (!issued[i] || done_at[i] != cyc) continue;
            for (int j = 0; j < n; j++)
               if (raw_m[i][j] && pend[j] > 0) pend[j]--;
         end
      end
      if (k > 0) begin
         issue_q[issue_q.size()-1].last  = 1'b1;
         issue_q[issue_q.size()-1].total = cyc[14:0];
      end
   endtask

   task automatic apply_word(logic [31:0] w);
      logic [1:0] op;
      logic [4:0] src;
      logic [4:0] dst;
      logic [1:0] kind;
      op   = w[1:0];
      src  = w[19:15];
      dst  = w[24:20];
      kind = w[26:25];
      case (op)
         OP_CLEAR: clear_graph_model();
         OP_LAT:   lat_tab[w[6:2]] = w[14:7];
         OP_EDGE: begin
            if (dst > src && kind != KIND_BAD) begin
               if (kind == KIND_RAW) raw_m[src][dst] = 1;
               else ord_m[src][dst] = 1;
            end
         end
         default: begin
            runs_seen++;
            schedule_run();
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Driver: bursts of words with random gaps
   // ---------------------------------------------------------------------
   int burst_left = 4;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_word(req_tdata);
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (graph_words.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= graph_words.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  // some bursts run back to back
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: own stall pattern, one long hold on request
   // ---------------------------------------------------------------------
   bit hold_armed = 0;
   bit hold_done  = 0;
   int hold_left  = 0;
   int mode       = 0;
   int mode_left  = 0;
   issue_rec_type exp_r;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (issue_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected issue word %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            exp_r = issue_q.pop_front();
            if (rsp_tdata[4:0] !== exp_r.node || rsp_tdata[18:5] !== exp_r.cyc ||
                rsp_tdata[31:19] !== exp_r.prio || rsp_tdata[46:32] !== exp_r.total ||
                rsp_tlast !== exp_r.last) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch: exp node %0d cyc %0d prio %0d last %b total %0d",
                     exp_r.node, exp_r.cyc, exp_r.prio, exp_r.last, exp_r.total);
                  $display("          got node %0d cyc %0d prio %0d last %b total %0d",
                     rsp_tdata[4:0], rsp_tdata[18:5], rsp_tdata[31:19], rsp_tlast,
                     rsp_tdata[46:32]);
               end
            end else results_ok++;
         end
      end
      if (hold_armed && !hold_done && hold_left == 0) begin
         hold_left = LONG_HOLD;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(5, 60);
         end
         mode_left--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic push_word(logic [1:0] op, logic [4:0] idx, logic [7:0] lat,
                            logic [4:0] src, logic [4:0] dst, logic [1:0] kind);
      graph_words.insert(graph_words.size(), {5'd0, kind, dst, src, lat, idx, op});
   endtask

   task automatic push_plain(logic [1:0] op);
      push_word(op, 5'($urandom), 8'($urandom), 5'($urandom), 5'($urandom),
                2'($urandom));
   endtask

   task automatic push_edge(int s, int d, logic [1:0] kind);
      push_word(OP_EDGE, 5'($urandom), 8'($urandom), s[4:0], d[4:0], kind);
   endtask

   // sender pauses until every issue word is back, then the block settles
   task automatic wait_idle();
      while (graph_words.size() != 0 || req_tvalid || issue_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_count(int v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[5:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      node_cfg = v;
      phases++;
   endtask

   // clear, load every active latency, random edges plus noise, one or two runs
   task automatic random_graph(int cfg);
      int n;
      int m;
      int s;
      int d;
      int lat;
      int pick;
      n = (cfg > NODES) ? NODES : cfg;
      push_plain(OP_CLEAR);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) lat = 0;
         else if (pick == 1 && n <= 6) lat = 255;
         else if (pick == 1) lat = $urandom_range(8, 20);
         else lat = $urandom_range(1, 6);
         push_word(OP_LAT, i[4:0], lat[7:0], 5'($urandom), 5'($urandom), 2'($urandom));
      end
      m = (n < 2) ? $urandom_range(0, 2) : $urandom_range(1, 2 * n);
      for (int e = 0; e < m; e++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7 && n >= 2) begin
            s = $urandom_range(0, n - 2);
            d = $urandom_range(s + 1, n - 1);
            push_edge(s, d, 2'($urandom_range(0, 2)));
         end else begin
            // backward, unknown kind or beyond the count
            push_edge($urandom_range(0, 31), $urandom_range(0, 31),
                      2'($urandom_range(0, 3)));
         end
      end
      push_plain(OP_RUN);
      if ($urandom_range(0, 4) == 0) push_plain(OP_RUN);
   endtask

   int pick_cfg;

   initial begin
      clear_graph_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset count of one, a zero latency entry is stepped up to the lowest nonzero value
      push_word(OP_LAT, 5'd0, 8'd0, 5'd31, 5'd31, 2'd3);
      push_plain(OP_RUN);
      wait_idle();

      // empty count gives no words
      write_count(0);
      push_plain(OP_RUN);
      push_plain(OP_CLEAR);

      // small graph with every edge flavor
      write_count(4);
      push_word(OP_LAT, 5'd0, 8'd255, 5'd0, 5'd0, 2'd0);
      push_word(OP_LAT, 5'd1, 8'd1, 5'd0, 5'd0, 2'd0);
      push_word(OP_LAT, 5'd2, 8'd200, 5'd0, 5'd0, 2'd0);
      push_word(OP_LAT, 5'd3, 8'd7, 5'd0, 5'd0, 2'd0);
      push_edge(0, 1, KIND_RAW);
      push_edge(0, 1, KIND_RAW);        // duplicate collapses
      push_edge(1, 2, 2'd1);            // WAR and WAW on one pair
      push_edge(1, 2, 2'd2);
      push_edge(2, 3, 2'd2);
      push_edge(3, 1, KIND_RAW);        // backward, ignored
      push_edge(0, 3, KIND_BAD);        // unknown kind, ignored
      push_edge(2, 3, KIND_RAW);
      push_edge(1, 31, KIND_RAW);       // beyond the count
      push_plain(OP_RUN);
      push_plain(OP_RUN);               // repeated run restarts

      // full table, receiver holds off while the sender keeps offering
      write_count(32);
      hold_armed = 1;
      random_graph(32);
      random_graph(32);

      // count above the table is limited
      write_count(63);
      random_graph(63);

      while (words_sent + graph_words.size() < 220 || phases < 6) begin
         pick_cfg = $urandom_range(0, 15);
         if (pick_cfg == 0) write_count(32);
         else if (pick_cfg == 1) write_count(63);
         else if (pick_cfg == 2) write_count(0);
         else write_count($urandom_range(1, 8));
         random_graph(node_cfg);
      end

      wait_idle();
      $display("covered %0d words, %0d runs, %0d issue words, %0d count settings",
               words_sent, runs_seen, results_ok, phases);
      if (errors == 0 && issue_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/cpls_pkg.sv
rtl/cpls_graph.sv
rtl/critical_path_list_scheduler.sv
test/tb_critical_path_list_scheduler.sv
